[sv/fvsc_pkg.sv]
// Shared constants for the floating valve step controller.
// Drive codes, field widths and register reset values; no dependencies.
`default_nettype none

package fvsc_pkg;

  localparam int TravelW  = 10;
  localparam int BandW    = 10;
  localparam int PeriodW  = 16;
  localparam int LateW    = 16;
  localparam int SetW     = 10;
  localparam int DriveW   = 2;
  localparam int PosW     = 20;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [DriveW-1:0] DRV_STOP  = 2'd0;
  localparam logic [DriveW-1:0] DRV_OPEN  = 2'd1;
  localparam logic [DriveW-1:0] DRV_CLOSE = 2'd2;
  localparam logic [DriveW-1:0] DRV_UNUSED = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_TRAVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BAND   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PERIOD = 2'd2;

  localparam logic [TravelW-1:0] TRAVEL_RST = 10'd10;
  localparam logic [BandW-1:0]   BAND_RST   = 10'd1;
  localparam logic [PeriodW-1:0] PERIOD_RST = 16'd1000;

  // Permille scale and the guard added to the action period.
  localparam logic [TravelW-1:0] SCALE_PERMILLE = 10'd1000;
  localparam logic [PeriodW:0]   GUARD_MS       = 17'd40;
  localparam logic [PeriodW-1:0] MAX_INTERVAL   = 16'hFFFF;

  // Derived reset values: 1000*travel and band*travel.
  localparam logic [PosW-1:0] MAXPOS_RST = 20'd10000;
  localparam logic [PosW-1:0] THR_RST    = 20'd10;

endpackage

`default_nettype wire

[sv/floating_valve_step_controller.sv]
// Top level of the floating valve step controller: config registers, input
// register, one-pass position update and result register. Uses fvsc_pkg.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  item    | item_valid, item_stall, lateness_ms,     | in
//          | setpoint                                 |
//  result  | result_valid, result_stall, drive,       | out
//          | next_interval_ms, position_estimate      |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One beat per cycle sustained while result_stall is low; an item passes the
// input register, then the result register. The position update loop
// (estimate -> clamp -> compare -> state) closes combinationally between those registers.
// Synchronous reset clears valids, drive state, position and last motion;
// config goes to travel 10 s, band 1, period 1000 ms. cfg_ready is always high.
// A stalled result holds and backs up into item_stall only when both stages fill.
`default_nettype none

module floating_valve_step_controller (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  output logic                             item_stall,
  input  wire  [fvsc_pkg::LateW-1:0]       lateness_ms,
  input  wire  [fvsc_pkg::SetW-1:0]        setpoint,
  output logic                             result_valid,
  input  wire                              result_stall,
  output logic [fvsc_pkg::DriveW-1:0]      drive,
  output logic [fvsc_pkg::PeriodW-1:0]     next_interval_ms,
  output logic [fvsc_pkg::PosW-1:0]        position_estimate,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [fvsc_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire  [fvsc_pkg::CfgDataW-1:0]    cfg_data
);
  import fvsc_pkg::*;

  // configuration and derived thresholds
  logic [TravelW-1:0] travel_time_s;
  logic [BandW-1:0]   dead_band;
  logic [PeriodW-1:0] action_period_ms;
  logic [PosW-1:0]    max_pos;
  logic [PosW-1:0]    band_thr;

  // controller state
  logic [DriveW-1:0]  drive_state;
  logic [PosW-1:0]    position_ms;
  logic [PeriodW-1:0] last_motion_ms;

  // input register
  logic               s1_valid;
  logic [LateW-1:0]   s1_late;
  logic [PosW-1:0]    s1_target;

  logic               advance;
  logic               cfg_write;
  logic [TravelW-1:0] cfg_travel;
  logic [BandW-1:0]   cfg_band;

  logic [LateW:0]     delta;
  logic [PosW:0]      pos_up;
  logic [PosW:0]      pos_int;
  logic [PosW-1:0]    pos_next;
  logic               up;
  logic [PosW-1:0]    err;
  logic               moving;
  logic               big;
  logic [PeriodW-1:0] interval;
  logic [DriveW-1:0]  drive_next;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid & cfg_ready;
  assign cfg_travel = cfg_data[TravelW-1:0];
  assign cfg_band   = cfg_data[BandW-1:0];

  assign advance    = s1_valid & (~result_valid | ~result_stall);
  assign item_stall = s1_valid & result_valid & result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_time_s    <= TRAVEL_RST;
      dead_band        <= BAND_RST;
      action_period_ms <= PERIOD_RST;
      max_pos          <= MAXPOS_RST;
      band_thr         <= THR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TRAVEL: begin
          travel_time_s <= cfg_travel;
          max_pos       <= PosW'(SCALE_PERMILLE) * PosW'(cfg_travel);
          band_thr      <= PosW'(dead_band) * PosW'(cfg_travel);
        end
        REG_BAND: begin
          dead_band <= cfg_band;
          band_thr  <= PosW'(cfg_band) * PosW'(travel_time_s);
        end
        REG_PERIOD: begin
          action_period_ms <= cfg_data[PeriodW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input register: target product formed on capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (~item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid & ~item_stall) begin
      s1_late   <= lateness_ms;
      s1_target <= PosW'(setpoint) * PosW'(travel_time_s);
    end
  end

  always_comb begin
    delta  = {1'b0, s1_late} + {1'b0, last_motion_ms};
    pos_up = {1'b0, position_ms} + (PosW+1)'(delta);
    case (drive_state)
      DRV_OPEN: begin
        pos_int = pos_up;
      end
      DRV_CLOSE: begin
        // floor at zero when closing past the stop
        if ((PosW+1)'(delta) > {1'b0, position_ms}) begin
          pos_int = '0;
        end else begin
          pos_int = {1'b0, position_ms} - (PosW+1)'(delta);
        end
      end
      default: begin
        pos_int = {1'b0, position_ms};
      end
    endcase
    if (pos_int > {1'b0, max_pos}) begin
      pos_next = max_pos;
    end else begin
      pos_next = pos_int[PosW-1:0];
    end

    up     = s1_target > pos_next;
    err    = up ? s1_target - pos_next : pos_next - s1_target;
    moving = (err != '0) && (err > band_thr);
    big    = err > PosW'({1'b0, action_period_ms} + GUARD_MS);

    if (!moving) begin
      interval   = action_period_ms;
      drive_next = DRV_STOP;
    end else begin
      if (big) begin
        interval = action_period_ms;
      end else if (err > PosW'(MAX_INTERVAL)) begin
        interval = MAX_INTERVAL;
      end else begin
        interval = err[PeriodW-1:0];
      end
      drive_next = up ? DRV_OPEN : DRV_CLOSE;
    end
  end

  // state and result register move together
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_state    <= DRV_STOP;
      position_ms    <= '0;
      last_motion_ms <= '0;
      result_valid   <= 1'b0;
      drive          <= DRV_STOP;
    end else begin
      if (advance) begin
        drive_state <= drive_next;
        position_ms <= pos_next;
        drive       <= drive_next;
        if (moving) begin
          last_motion_ms <= interval;
        end
        result_valid <= 1'b1;
      end else if (~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      next_interval_ms  <= interval;
      position_estimate <= pos_next;
    end
  end

`ifndef NO_ASSERTIONS
  // the delivered drive always mirrors the controller state
  a_drive_tracks_state: assert property (@(posedge clk) disable iff (rst)
    drive == drive_state)
    else $error("result drive differs from drive state");

  a_no_unused_drive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> drive != DRV_UNUSED)
    else $error("unused drive code on result");

  // an item in the input register with a free result slot lands next cycle
  a_item_lands: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !result_valid |=> result_valid)
    else $error("item lost between input and result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("item_stall raised with free space");
`endif

endmodule

`default_nettype wire

[verif/valve_drive_checker.sv]
// Result checker for the floating valve step controller testbench.
// Tracks registers and valve state from observed beats, predicts every result
// and compares it field by field. Depends on fvsc_pkg.
module valve_drive_checker (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            item_valid,
  input  wire                            item_stall,
  input  wire  [fvsc_pkg::LateW-1:0]     lateness_ms,
  input  wire  [fvsc_pkg::SetW-1:0]      setpoint,
  input  wire                            result_valid,
  input  wire                            result_stall,
  input  wire  [fvsc_pkg::DriveW-1:0]    drive,
  input  wire  [fvsc_pkg::PeriodW-1:0]   next_interval_ms,
  input  wire  [fvsc_pkg::PosW-1:0]      position_estimate,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire  [fvsc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire  [fvsc_pkg::CfgDataW-1:0]  cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import fvsc_pkg::*;

  typedef struct packed {
    logic [DriveW-1:0]  drive;
    logic [PeriodW-1:0] interval;
    logic [PosW-1:0]    position;
  } valve_cmd_t;

  valve_cmd_t due_cmds[$];

  logic [TravelW-1:0] travel_s;
  logic [BandW-1:0]   band;
  logic [PeriodW-1:0] period_ms;
  logic [DriveW-1:0]  motion;
  logic [PosW-1:0]    pos_ms;
  logic [PeriodW-1:0] last_run_ms;

  // Integrate the last motion, clamp, then pick the next drive and interval.
  function automatic valve_cmd_t integrate_and_decide(input logic [LateW-1:0] late,
                                                      input logic [SetW-1:0] sp);
    longint pos, max_pos, target, err, run;
    valve_cmd_t cmd;
    pos = longint'(pos_ms);
    max_pos = longint'(SCALE_PERMILLE) * longint'(travel_s);
    if (motion == DRV_OPEN) pos = pos + longint'(late) + longint'(last_run_ms);
    else if (motion == DRV_CLOSE) pos = pos - longint'(late) - longint'(last_run_ms);
    if (pos < 0) pos = 0;
    if (pos > max_pos) pos = max_pos;
    pos_ms = pos[PosW-1:0];

    target = longint'(sp) * longint'(travel_s);
    err = (target > pos) ? target - pos : pos - target;
    if (err != 0 && err > longint'(band) * longint'(travel_s)) begin
      run = (err > longint'(period_ms) + longint'(GUARD_MS)) ? longint'(period_ms) : err;
      if (run > longint'(MAX_INTERVAL)) run = longint'(MAX_INTERVAL);
      last_run_ms = run[PeriodW-1:0];
      motion = (target > pos) ? DRV_OPEN : DRV_CLOSE;
    end else begin
      run = longint'(period_ms);
      motion = DRV_STOP;
    end
    cmd.drive = motion;
    cmd.interval = run[PeriodW-1:0];
    cmd.position = pos_ms;
    return cmd;
  endfunction

  always @(posedge clk) begin
    valve_cmd_t want;
    if (rst) begin
      travel_s = TRAVEL_RST;
      band = BAND_RST;
      period_ms = PERIOD_RST;
      motion = DRV_STOP;
      pos_ms = '0;
      last_run_ms = '0;
      mismatches = 0;
      due_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRAVEL: travel_s = cfg_data[TravelW-1:0];
          REG_BAND:   band = cfg_data[BandW-1:0];
          REG_PERIOD: period_ms = cfg_data[PeriodW-1:0];
          default: ;
        endcase
      end
      // Results are checked before this edge's item is queued.
      if (result_valid && !result_stall) begin
        if (due_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result beat drive %0d interval %0d position %0d",
                     $time, drive, next_interval_ms, position_estimate);
        end else begin
          want = due_cmds.pop_front();
          if (drive !== want.drive || next_interval_ms !== want.interval ||
              position_estimate !== want.position) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch exp drive %0d interval %0d position %0d,",
                        " got %0d %0d %0d"},
                       $time, want.drive, want.interval, want.position,
                       drive, next_interval_ms, position_estimate);
          end
        end
      end
      if (item_valid && !item_stall)
        due_cmds.push_back(integrate_and_decide(lateness_ms, setpoint));
    end
    pending = due_cmds.size();
  end

endmodule

[verif/tb_floating_valve_step_controller.sv]
// Testbench top for the floating valve step controller: clock, reset, update
// and register stimulus, receiver stalls and the verdict. Depends on fvsc_pkg,
// the controller RTL and valve_drive_checker.
module tb_floating_valve_step_controller;
  import fvsc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 8;
  localparam int SEG_ITEMS   = 210;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [LateW-1:0]    lateness_ms = '0;
  logic [SetW-1:0]     setpoint = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [DriveW-1:0]   drive;
  logic [PeriodW-1:0]  next_interval_ms;
  logic [PosW-1:0]     position_estimate;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int       mismatches;
  int       pending;
  int       cycles = 0;
  int       burst_left = 0;
  int       hold_req = 0;
  int       hold_seen = 0;
  int       hold_cnt = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;

  always #10 clk = ~clk;

  floating_valve_step_controller u_dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .lateness_ms       (lateness_ms),
    .setpoint          (setpoint),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .drive             (drive),
    .next_interval_ms  (next_interval_ms),
    .position_estimate (position_estimate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  valve_drive_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .lateness_ms       (lateness_ms),
    .setpoint          (setpoint),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .drive             (drive),
    .next_interval_ms  (next_interval_ms),
    .position_estimate (position_estimate),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall modes, plus a long hold-off on each request.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_FREE:  result_stall <= 1'b0;
        RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: result_stall <= ($urandom_range(0, 4) != 0);
        default:  result_stall <= ~result_stall;
      endcase
    end
  end

  task automatic send_update(input logic [LateW-1:0] late, input logic [SetW-1:0] sp);
    @(negedge clk);
    item_valid <= 1'b1;
    lateness_ms <= late;
    setpoint <= sp;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic pause_updates(input int n);
    repeat (n) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic offer_update(input logic [LateW-1:0] late, input logic [SetW-1:0] sp);
    if (burst_left == 0) begin
      pause_updates($urandom_range(0, 6));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_update(late, sp);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_config;
    logic [CfgDataW-1:0] d;
    case ($urandom_range(0, 7))
      0: d = 16'd0;
      1: d = 16'd1;
      2: d = 16'd1023;
      default: d = CfgDataW'($urandom_range(2, 40));
    endcase
    // junk in the unused upper bits must be dropped
    if ($urandom_range(0, 3) == 0) d[CfgDataW-1:TravelW] = (CfgDataW-TravelW)'($urandom);
    write_reg(REG_TRAVEL, d);
    case ($urandom_range(0, 7))
      0: d = 16'd1023;
      1: d = CfgDataW'($urandom_range(0, 1023));
      default: d = CfgDataW'($urandom_range(0, 3));
    endcase
    if ($urandom_range(0, 3) == 0) d[CfgDataW-1:BandW] = (CfgDataW-BandW)'($urandom);
    write_reg(REG_BAND, d);
    case ($urandom_range(0, 7))
      0: d = 16'd0;
      1: d = 16'd1;
      2: d = 16'hFFFF;
      3, 4: d = CfgDataW'($urandom_range(1, 100));
      default: d = CfgDataW'($urandom_range(100, 3000));
    endcase
    write_reg(REG_PERIOD, d);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CfgDataW'($urandom));
  endtask

  initial begin
    logic [LateW-1:0] late;
    logic [SetW-1:0]  held_sp;
    held_sp = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: travel 10 s, band 1, period 1000 ms.
    offer_update(16'hFFFF, 10'd0);     // stopped valve ignores lateness
    offer_update(16'd0, 10'd1000);     // large error, open for one period
    offer_update(16'd0, 10'd1000);
    offer_update(16'hFFFF, 10'd1000);  // overshoot clamps at full stroke
    offer_update(16'd0, 10'd1023);     // setpoint above range, short run
    offer_update(16'd5, 10'd999);      // error equal to the band: stop
    offer_update(16'd0, 10'd998);      // short close
    offer_update(16'hFFFF, 10'd0);     // clamps at zero
    drain;

    // 66*993 = 65538: run longer than 16 bits saturates.
    write_reg(REG_TRAVEL, 16'hFC00 | 16'd66);
    write_reg(REG_BAND, 16'd0);
    write_reg(REG_PERIOD, 16'hFFFF);
    write_reg(REG_SPARE, 16'hFFFF);
    offer_update(16'd0, 10'd993);
    offer_update(16'hFFFF, 10'd0);
    offer_update(16'd0, 10'd500);
    drain;

    // Zero travel and zero period.
    write_reg(REG_TRAVEL, 16'd0);
    write_reg(REG_BAND, 16'd1023);
    write_reg(REG_PERIOD, 16'd0);
    offer_update(16'd123, 10'd1000);
    offer_update(16'hFFFF, 10'd1023);
    drain;

    write_reg(REG_TRAVEL, 16'd1023);
    write_reg(REG_BAND, 16'd0);
    write_reg(REG_PERIOD, 16'd1);
    offer_update(16'd0, 10'd1023);
    offer_update(16'hFFFF, 10'd1023);
    offer_update(16'd0, 10'd0);
    offer_update(16'd0, 10'd1);
    drain;

    // Band as wide as the stroke: never moves.
    write_reg(REG_TRAVEL, 16'd1);
    write_reg(REG_BAND, 16'd1000);
    write_reg(REG_PERIOD, 16'hFFFF);
    offer_update(16'd7, 10'd1000);
    offer_update(16'd0, 10'd0);
    drain;

    for (int s = 0; s < SEGMENTS; s++) begin
      random_config;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i == SEG_ITEMS / 2 && (s == 2 || s == 5)) begin
          @(negedge clk);
          item_valid <= 1'b0;
          hold_req <= hold_req + 1;
          burst_left = 80;
        end
        // setpoint held for a while so the estimate can settle on it
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 5))
            0: held_sp = 10'd0;
            1: held_sp = 10'd1000;
            2: held_sp = 10'd1023;
            default: held_sp = SetW'($urandom_range(0, 1023));
          endcase
        end
        case ($urandom_range(0, 9))
          0: late = LateW'($urandom);
          1, 2: late = LateW'($urandom_range(0, 2000));
          default: late = LateW'($urandom_range(0, 20));
        endcase
        offer_update(late, held_sp);
      end
      drain;
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[floating_valve_step_controller.f]
sv/fvsc_pkg.sv
sv/floating_valve_step_controller.sv
verif/valve_drive_checker.sv
verif/tb_floating_valve_step_controller.sv
